/* src/byte_charset_unicode_map_top_defines.svh */
// assertion macros used by the checker file
`ifndef BYTE_CHARSET_UNICODE_MAP_TOP_DEFINES_SVH
`define BYTE_CHARSET_UNICODE_MAP_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BCUM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BCUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that is also checked around reset
`define BCUM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* src/bcum_pkg.sv */
// types and constants of the byte charset mapping block
package bcum_pkg;

  typedef enum logic [1:0] {
    ACT_ADD_PAIR = 2'd0,
    ACT_B2W      = 2'd1,
    ACT_W2B      = 2'd2,
    ACT_FILL     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL_RD,
    ST_FILL_WR
  } state_t;

  localparam logic [15:0] UNMAPPED16 = 16'hFFFF;
  localparam logic [7:0]  LAST_BYTE  = 8'hFF;
  localparam logic [15:0] LAST_CODE  = 16'hFFFF;

  typedef struct packed {
    logic        rd_en;
    logic [7:0]  rd_addr;
    logic        wr_en;
    logic [7:0]  wr_addr;
    logic [15:0] wr_data;
  } fwd_req_t;

  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [8:0]  wr_data;
  } rev_req_t;

endpackage

/* src/bcum_fwd_mem.sv */
// forward table, byte to 16-bit code, with per-entry valid bits
module bcum_fwd_mem (
  input  logic              clk,
  input  logic              rst,
  input  bcum_pkg::fwd_req_t req,
  output logic [15:0]       rd_code
);

  logic [15:0]  mem [256];
  logic [255:0] valid;
  logic [15:0]  rd_data;
  logic         rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  // never-written entries read as unmapped
  assign rd_code = rd_valid ? rd_data : bcum_pkg::UNMAPPED16;

endmodule

/* src/bcum_rev_mem.sv */
// reverse table, 16-bit code to valid flag and byte
module bcum_rev_mem (
  input  logic              clk,
  input  bcum_pkg::rev_req_t req,
  output logic [8:0]        rd_entry
);

  logic [8:0] mem [65536];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_addr];
    end
  end

endmodule

/* src/bcum_ctrl.sv */
// sequencer: clearing pass, table read-modify-write, identity fill, result register
module bcum_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  output logic [0:0]         m_tuser,
  output logic               m_tlast,
  output bcum_pkg::fwd_req_t fwd_req,
  output bcum_pkg::rev_req_t rev_req,
  input  logic [15:0]        fwd_rd,
  input  logic [8:0]         rev_rd
);

  bcum_pkg::state_t  state, state_next;
  bcum_pkg::action_t act;
  logic [7:0]        bval;
  logic [15:0]       wval;
  logic              eos;
  logic [15:0]       clr_addr;
  logic [7:0]        fill_idx;
  logic              out_load;
  logic [15:0]       out_code;
  logic              out_mapped;
  logic              fwd_free;

  assign fwd_free = (fwd_rd == bcum_pkg::UNMAPPED16);

  always_comb begin
    state_next = state;
    case (state)
      bcum_pkg::ST_CLEAR: begin
        if (clr_addr == bcum_pkg::LAST_CODE) state_next = bcum_pkg::ST_IDLE;
      end
      bcum_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = bcum_pkg::ST_EXEC;
      end
      bcum_pkg::ST_EXEC: begin
        case (act)
          bcum_pkg::ACT_ADD_PAIR: state_next = bcum_pkg::ST_IDLE;
          bcum_pkg::ACT_FILL:     state_next = bcum_pkg::ST_FILL_RD;
          default: begin
            if (!m_tvalid || m_tready) state_next = bcum_pkg::ST_IDLE;
          end
        endcase
      end
      bcum_pkg::ST_FILL_RD: state_next = bcum_pkg::ST_FILL_WR;
      bcum_pkg::ST_FILL_WR: begin
        if (fill_idx == bcum_pkg::LAST_BYTE) state_next = bcum_pkg::ST_IDLE;
        else state_next = bcum_pkg::ST_FILL_RD;
      end
      default: state_next = bcum_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    out_load   = 1'b0;
    out_code   = 16'h0000;
    out_mapped = 1'b0;
    fwd_req    = '0;
    rev_req    = '0;
    case (state)
      bcum_pkg::ST_CLEAR: begin
        rev_req.wr_en   = 1'b1;
        rev_req.wr_addr = clr_addr;
        rev_req.wr_data = 9'h000;
      end
      bcum_pkg::ST_IDLE: begin
        s_tready        = 1'b1;
        fwd_req.rd_en   = 1'b1;
        fwd_req.rd_addr = s_tdata[7:0];
        rev_req.rd_en   = 1'b1;
        rev_req.rd_addr = s_tdata[23:8];
      end
      bcum_pkg::ST_EXEC: begin
        case (act)
          bcum_pkg::ACT_ADD_PAIR: begin
            // first write wins in each direction
            rev_req.wr_en   = !rev_rd[8];
            rev_req.wr_addr = wval;
            rev_req.wr_data = {1'b1, bval};
            fwd_req.wr_en   = fwd_free;
            fwd_req.wr_addr = bval;
            fwd_req.wr_data = wval;
          end
          bcum_pkg::ACT_B2W: begin
            out_load   = !m_tvalid || m_tready;
            out_mapped = !fwd_free;
            out_code   = fwd_free ? 16'h0000 : fwd_rd;
          end
          bcum_pkg::ACT_W2B: begin
            out_load   = !m_tvalid || m_tready;
            out_mapped = rev_rd[8];
            out_code   = rev_rd[8] ? {8'h00, rev_rd[7:0]} : 16'h0000;
          end
          default: begin
          end
        endcase
      end
      bcum_pkg::ST_FILL_RD: begin
        fwd_req.rd_en   = 1'b1;
        fwd_req.rd_addr = fill_idx;
        rev_req.rd_en   = 1'b1;
        rev_req.rd_addr = {8'h00, fill_idx};
      end
      bcum_pkg::ST_FILL_WR: begin
        // identity pair only where both directions are still free
        rev_req.wr_en   = !rev_rd[8] && fwd_free;
        rev_req.wr_addr = {8'h00, fill_idx};
        rev_req.wr_data = {1'b1, fill_idx};
        fwd_req.wr_en   = !rev_rd[8] && fwd_free;
        fwd_req.wr_addr = fill_idx;
        fwd_req.wr_data = {8'h00, fill_idx};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bcum_pkg::ST_CLEAR;
      clr_addr <= '0;
      fill_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bcum_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 16'd1;
      end
      if (state == bcum_pkg::ST_EXEC) begin
        fill_idx <= '0;
      end else if (state == bcum_pkg::ST_FILL_WR) begin
        fill_idx <= fill_idx + 8'd1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act  <= bcum_pkg::action_t'(s_tuser);
      bval <= s_tdata[7:0];
      wval <= s_tdata[23:8];
      eos  <= s_tlast;
    end
    if (out_load) begin
      m_tdata    <= out_code;
      m_tuser[0] <= out_mapped;
      m_tlast    <= eos;
    end
  end

endmodule

/* src/byte_charset_unicode_map_top.sv */
// top level of the byte charset to 16-bit code mapping block
//
// input beats carry one action each: add pair, byte to wide, wide to byte or
// identity fill (s_tuser). s_tdata holds the byte and the 16-bit code,
// s_tlast marks the last character of a string.
// byte to wide and wide to byte return one beat each on the m_ side with the
// converted code in m_tdata, the mapped flag in m_tuser and s_tlast copied to
// m_tlast; add pair and identity fill return nothing.
// each item is accepted in the idle state, which reads both tables; in the next
// cycle the execute state uses the registered read data and writes back. a result
// is loaded into the output register from the execute state once that register is
// free. identity fill then does a read and a write-back step per byte value.
// the output register holds one result; while it waits, the next beat is
// still taken, and a later conversion waits in the execute state until the
// register is free.
// after reset the reverse table is cleared one entry a cycle, all 65536 entries,
// with s_tready low; the forward table clears at once through valid bits.
module byte_charset_unicode_map_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // byte_value [7:0], code_value [23:8]
  input  logic [1:0]  s_tuser,   // action [1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_code [15:0]
  output logic [0:0]  m_tuser,   // mapped [0]
  output logic        m_tlast
);

  bcum_pkg::fwd_req_t fwd_req;
  bcum_pkg::rev_req_t rev_req;
  logic [15:0]        fwd_rd;
  logic [8:0]         rev_rd;

  bcum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .fwd_req  (fwd_req),
    .rev_req  (rev_req),
    .fwd_rd   (fwd_rd),
    .rev_rd   (rev_rd)
  );

  bcum_fwd_mem u_fwd_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (fwd_req),
    .rd_code (fwd_rd)
  );

  bcum_rev_mem u_rev_mem (
    .clk      (clk),
    .req      (rev_req),
    .rd_entry (rev_rd)
  );

endmodule

/* src/bcum_checker.sv */
// port-level checks of the mapping block and their binding
`include "byte_charset_unicode_map_top_defines.svh"

module bcum_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `BCUM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `BCUM_ASSERT_NOW(a_unmapped_zero, m_tvalid && !m_tuser[0], m_tdata == 16'h0000, "unmapped result with nonzero code")
  `BCUM_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second beat taken while an item is at work")
  `BCUM_ASSERT_ALWAYS(a_reset_quiet, $past(rst), !m_tvalid && !s_tready, "block active right after reset")

endmodule

bind byte_charset_unicode_map_top bcum_checker u_checker (.*);
